// ===== sv/rrts_pkg.sv =====
package rrts_pkg;

  // sizing
  localparam int THREADS    = 8;
  localparam int SEMAPHORES = 8;
  localparam int TID_W      = $clog2(THREADS);
  localparam int SEM_IW     = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam int TAG_W      = $clog2(SEMAPHORES + 1);

  // beat field types
  typedef logic [2:0]         op_t;
  typedef logic [2:0]         id_t;
  typedef logic [31:0]        ticks_t;
  typedef logic signed [15:0] sem_val_t;
  typedef logic [1:0]         status_t;

  // internal types
  typedef logic [TID_W-1:0]   tid_t;
  typedef logic [SEM_IW-1:0]  sidx_t;
  typedef logic [TAG_W-1:0]   tag_t;

  // opcodes
  localparam op_t OP_CREATE = 3'd0;
  localparam op_t OP_WAIT   = 3'd1;
  localparam op_t OP_SIGNAL = 3'd2;
  localparam op_t OP_SLEEP  = 3'd3;
  localparam op_t OP_TICK   = 3'd4;
  localparam op_t OP_SWITCH = 3'd5;
  localparam op_t OP_INIT   = 3'd6;
  localparam op_t OP_NOP    = 3'd7;

  // status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NORUN    = 2'd1;
  localparam status_t ST_NOWAITER = 2'd2;
  localparam status_t ST_SAT      = 2'd3;

  localparam sem_val_t SEM_MIN = 16'sh8000;
  localparam sem_val_t SEM_MAX = 16'sh7fff;

  // write command into the thread table
  typedef struct packed {
    logic   we_sleep;
    logic   we_tag;
    tid_t   idx;
    ticks_t sleep;
    tag_t   tag;
  } tt_wr_t;

  // one finished result
  typedef struct packed {
    id_t      running_thread;
    logic     switched;
    sem_val_t sem_value;
    logic     woken_valid;
    id_t      woken_thread;
    status_t  status;
  } res_t;

  // next thread in the ring
  function automatic tid_t ring_next(input tid_t t);
    return (t == TID_W'(THREADS - 1)) ? '0 : t + TID_W'(1);
  endfunction

endpackage

// ===== sv/rrts_if.sv =====
interface rrts_in_if;
  logic              valid;
  logic              ready;
  rrts_pkg::op_t     opcode;
  rrts_pkg::id_t     thread_id;
  rrts_pkg::id_t     sem_id;
  rrts_pkg::ticks_t  sleep_ticks;
  rrts_pkg::sem_val_t init_value;

  modport source (output valid, opcode, thread_id, sem_id, sleep_ticks, init_value,
                  input ready);
  modport sink   (input valid, opcode, thread_id, sem_id, sleep_ticks, init_value,
                  output ready);
endinterface

interface rrts_out_if;
  logic               valid;
  logic               ready;
  rrts_pkg::id_t      running_thread;
  logic               switched;
  rrts_pkg::sem_val_t sem_value;
  logic               woken_valid;
  rrts_pkg::id_t      woken_thread;
  rrts_pkg::status_t  status;

  modport source (output valid, running_thread, switched, sem_value, woken_valid,
                  woken_thread, status, input ready);
  modport sink   (input valid, running_thread, switched, sem_value, woken_valid,
                  woken_thread, status, output ready);
endinterface

// ===== sv/rrts_thread_tbl.sv =====
module rrts_thread_tbl (
  input  logic             clk,
  input  logic             rst_n,
  input  rrts_pkg::tid_t   rd_idx,
  output rrts_pkg::ticks_t rd_sleep,
  output rrts_pkg::tag_t   rd_tag,
  input  rrts_pkg::tt_wr_t wr
);
  import rrts_pkg::*;

  ticks_t sleep_r [THREADS];
  tag_t   tag_r   [THREADS];

  // single read port at the scan pointer
  assign rd_sleep = sleep_r[rd_idx];
  assign rd_tag   = tag_r[rd_idx];

  // single write port, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < THREADS; i++) begin
        sleep_r[i] <= '0;
        tag_r[i]   <= '0;
      end
    end else begin
      if (wr.we_sleep) sleep_r[wr.idx] <= wr.sleep;
      if (wr.we_tag)   tag_r[wr.idx]   <= wr.tag;
    end
  end

endmodule

// ===== sv/rrts_seq.sv =====
module rrts_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrts_pkg::op_t      in_opcode,
  input  rrts_pkg::id_t      in_thread_id,
  input  rrts_pkg::id_t      in_sem_id,
  input  rrts_pkg::ticks_t   in_sleep_ticks,
  input  rrts_pkg::sem_val_t in_init_value,
  output logic               res_valid,
  output rrts_pkg::res_t     res,
  input  logic               res_free,
  output rrts_pkg::tid_t     tt_rd_idx,
  input  rrts_pkg::ticks_t   tt_rd_sleep,
  input  rrts_pkg::tag_t     tt_rd_tag,
  output rrts_pkg::tt_wr_t   tt_wr
);
  import rrts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_SIG  = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  tid_t       cur_r, cur_nxt;
  sem_val_t   sem_r [SEMAPHORES];

  op_t      op_r;
  id_t      tid_r, sid_r;
  ticks_t   ticks_r;
  sem_val_t ival_r;
  tid_t     before_r;
  tid_t     ptr_r, ptr_nxt;
  tid_t     cnt_r, cnt_nxt;
  status_t  status_r, status_nxt;
  sem_val_t semv_r, semv_nxt;
  logic     wvalid_r, wvalid_nxt;
  tid_t     wthread_r, wthread_nxt;

  logic     sem_we;
  sem_val_t sem_wdata;
  sidx_t    sem_idx;
  sem_val_t sem_cur, sem_dec, sem_inc;
  logic     sem_ok, tid_ok, last;
  tag_t     sid_tag;
  tid_t     tid_idx;

  assign sem_idx = SEM_IW'(sid_r);
  assign tid_idx = TID_W'(tid_r);
  assign sem_ok  = 32'(sid_r) < 32'(SEMAPHORES);
  assign tid_ok  = 32'(tid_r) < 32'(THREADS);
  assign sem_cur = sem_r[sem_idx];
  assign sem_dec = sem_cur - 16'sd1;
  assign sem_inc = sem_cur + 16'sd1;
  assign sid_tag = TAG_W'(sid_r) + TAG_W'(1);
  assign last    = (cnt_r == TID_W'(THREADS - 1));

  assign in_ready  = (state_r == S_IDLE);
  assign tt_rd_idx = ptr_r;
  assign res_valid = (state_r == S_DONE) && res_free;

  // result assembled from the held item state
  always_comb begin
    res.running_thread = 3'(cur_r);
    res.switched       = (cur_r != before_r);
    res.sem_value      = semv_r;
    res.woken_valid    = wvalid_r;
    res.woken_thread   = 3'(wthread_r);
    res.status         = status_r;
  end

  // sequencer: an exec state, then for a pick, signal or tick a scan of one ring entry per cycle
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    semv_nxt    = semv_r;
    wvalid_nxt  = wvalid_r;
    wthread_nxt = wthread_r;
    sem_we      = 1'b0;
    sem_wdata   = sem_cur;
    tt_wr       = '0;
    tt_wr.idx   = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt   = S_EXEC;
          status_nxt  = ST_OK;
          semv_nxt    = '0;
          wvalid_nxt  = 1'b0;
          wthread_nxt = '0;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        ptr_nxt   = ring_next(cur_r);
        cnt_nxt   = '0;
        case (op_r)
          OP_CREATE: begin
            if (tid_ok) begin
              tt_wr.we_sleep = 1'b1;
              tt_wr.we_tag   = 1'b1;
              tt_wr.idx      = tid_idx;
            end
          end
          OP_WAIT: begin
            if (sem_ok) begin
              if (sem_cur == SEM_MIN) begin
                status_nxt = ST_SAT;
                semv_nxt   = sem_cur;
              end else begin
                sem_we    = 1'b1;
                sem_wdata = sem_dec;
                semv_nxt  = sem_dec;
                if (sem_dec[15]) begin
                  tt_wr.we_tag = 1'b1;
                  tt_wr.tag    = sid_tag;
                  state_nxt    = S_PICK;
                end
              end
            end
          end
          OP_SIGNAL: begin
            if (sem_ok) begin
              if (sem_cur == SEM_MAX) begin
                status_nxt = ST_SAT;
                semv_nxt   = sem_cur;
              end else begin
                sem_we    = 1'b1;
                sem_wdata = sem_inc;
                semv_nxt  = sem_inc;
                if (sem_inc[15] || (sem_inc == 16'sd0)) begin
                  status_nxt = ST_NOWAITER;
                  state_nxt  = S_SIG;
                end
              end
            end
          end
          OP_SLEEP: begin
            tt_wr.we_sleep = 1'b1;
            tt_wr.sleep    = ticks_r;
            state_nxt      = S_PICK;
          end
          OP_TICK: begin
            ptr_nxt   = '0;
            state_nxt = S_TICK;
          end
          OP_SWITCH: begin
            state_nxt = S_PICK;
          end
          OP_INIT: begin
            if (sem_ok) begin
              sem_we    = 1'b1;
              sem_wdata = ival_r;
              semv_nxt  = ival_r;
            end
          end
          default: ;
        endcase
      end
      // round-robin search for a runnable thread
      S_PICK: begin
        if ((tt_rd_sleep == '0) && (tt_rd_tag == '0)) begin
          cur_nxt   = ptr_r;
          state_nxt = S_DONE;
        end else if (last) begin
          status_nxt = ST_NORUN;
          state_nxt  = S_DONE;
        end else begin
          ptr_nxt = ring_next(ptr_r);
          cnt_nxt = cnt_r + TID_W'(1);
        end
      end
      // first waiter after the running thread
      S_SIG: begin
        if (tt_rd_tag == sid_tag) begin
          tt_wr.we_tag = 1'b1;
          tt_wr.idx    = ptr_r;
          tt_wr.tag    = '0;
          wvalid_nxt   = 1'b1;
          wthread_nxt  = ptr_r;
          status_nxt   = ST_OK;
          state_nxt    = S_DONE;
        end else if (last) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ring_next(ptr_r);
          cnt_nxt = cnt_r + TID_W'(1);
        end
      end
      // decrement each nonzero sleep counter in turn
      S_TICK: begin
        if (tt_rd_sleep != '0) begin
          tt_wr.we_sleep = 1'b1;
          tt_wr.idx      = ptr_r;
          tt_wr.sleep    = tt_rd_sleep - 32'd1;
        end
        if (last) begin
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = ring_next(ptr_r);
          cnt_nxt = cnt_r + TID_W'(1);
        end
      end
      S_DONE: begin
        if (res_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and semaphore table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      for (int i = 0; i < SEMAPHORES; i++) sem_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      if (sem_we) sem_r[sem_idx] <= sem_wdata;
    end
  end

  // item payload and scan registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_opcode;
      tid_r    <= in_thread_id;
      sid_r    <= in_sem_id;
      ticks_r  <= in_sleep_ticks;
      ival_r   <= in_init_value;
      before_r <= cur_r;
    end
    ptr_r     <= ptr_nxt;
    cnt_r     <= cnt_nxt;
    status_r  <= status_nxt;
    semv_r    <= semv_nxt;
    wvalid_r  <= wvalid_nxt;
    wthread_r <= wthread_nxt;
  end

endmodule

// ===== sv/round_robin_thread_scheduler_top.sv =====
// flow: create, init and semaphore ops that do not block go from the exec state straight
//   to the done state; a pick, signal or tick first runs a ring scan that visits one
//   thread table entry per cycle
// handshake: one item at a time; a new beat is taken once the result sits in the output
//   register, which holds it until the sink takes it
// reset: synchronous, active low; clears all tables and runs thread zero, no sweep
module round_robin_thread_scheduler_top (
  input logic        clk,
  input logic        rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch
);
  import rrts_pkg::*;

  logic   res_valid, res_free;
  res_t   res;
  tid_t   tt_rd_idx;
  ticks_t tt_rd_sleep;
  tag_t   tt_rd_tag;
  tt_wr_t tt_wr;

  logic out_valid_r;
  res_t out_r;

  rrts_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_opcode      (in_ch.opcode),
    .in_thread_id   (in_ch.thread_id),
    .in_sem_id      (in_ch.sem_id),
    .in_sleep_ticks (in_ch.sleep_ticks),
    .in_init_value  (in_ch.init_value),
    .res_valid      (res_valid),
    .res            (res),
    .res_free       (res_free),
    .tt_rd_idx      (tt_rd_idx),
    .tt_rd_sleep    (tt_rd_sleep),
    .tt_rd_tag      (tt_rd_tag),
    .tt_wr          (tt_wr)
  );

  rrts_thread_tbl u_thread_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (tt_rd_idx),
    .rd_sleep (tt_rd_sleep),
    .rd_tag   (tt_rd_tag),
    .wr       (tt_wr)
  );

  // output register
  assign res_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.running_thread = out_r.running_thread;
  assign out_ch.switched       = out_r.switched;
  assign out_ch.sem_value      = out_r.sem_value;
  assign out_ch.woken_valid    = out_r.woken_valid;
  assign out_ch.woken_thread   = out_r.woken_thread;
  assign out_ch.status         = out_r.status;

endmodule
